>>> src/assert_macros.svh
// assertion macros used by the checker file bfvm_checker.sv
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

// condition that must hold in the cycle after reset is applied
`define ASSERT_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

>>> src/bfvm_pkg.sv
// shared widths, constants and types of the breath flow volume monitor
// no dependencies; imported by the top level and its checker
package bfvm_pkg;

  localparam int FLOW_W   = 13;
  localparam int GAIN_W   = 16;
  localparam int HZ_W     = 10;
  localparam int VOL_W    = 16;
  localparam int RATE_W   = 16;
  localparam int MV_W     = 24;
  localparam int BELOW_W  = 8;
  localparam int ACC_W    = 32;

  localparam int END_COUNT_LIMIT = 10;
  localparam int ELAPSED_WIDTH   = 24;

  // flow times gain, signed
  localparam int VPROD_W    = FLOW_W + GAIN_W;
  // 1/16 breaths per minute: 60 s * 16
  localparam int RATE_SCALE = 960;
  localparam int DIVIDEND_W = $clog2(RATE_SCALE * ((1 << HZ_W) - 1) + 1);
  localparam int MV_PROD_W  = RATE_W + VOL_W;
  localparam int MV_SHIFT   = 4;
  localparam int CNT_W      = $clog2(DIVIDEND_W + 1);

  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int IDX_W  = ADDR_W - 2;

  localparam int THRESHOLD_LOW_RST     = 80;
  localparam int THRESHOLD_HIGH_RST    = 160;
  localparam int SAMPLE_RATE_HZ_RST    = 33;
  localparam int VOLUME_GAIN_RST       = 2069;
  localparam int RATE_MIN_RST          = 272;
  localparam int RATE_MAX_RST          = 352;
  localparam int MINUTE_VOLUME_MIN_RST = 5000;
  localparam int MINUTE_VOLUME_MAX_RST = 8000;

  typedef enum logic [IDX_W-1:0] {
    REG_THRESHOLD_LOW,
    REG_THRESHOLD_HIGH,
    REG_SAMPLE_RATE_HZ,
    REG_VOLUME_GAIN,
    REG_RATE_MIN,
    REG_RATE_MAX,
    REG_MINUTE_VOLUME_MIN,
    REG_MINUTE_VOLUME_MAX
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_MV,
    ST_DONE
  } state_t;

endpackage

>>> src/breath_flow_volume_monitor.sv
// breath flow volume monitor: volume integration, breath detection, rate and alarms
// depends on bfvm_pkg; checked by bfvm_checker, bound in its own file
//
// One flow sample in, one result out. After a sample is accepted, in_ready
// returns once its result is loaded into the output register. An ordinary
// sample runs the serial multiplier that forms flow times volume_gain one
// gain bit per cycle (16 steps); a breath start adds the restoring divider
// for the respiratory rate, one quotient bit per cycle (20 steps, running
// alongside the multiplier), and a 16-step shift-add for minute volume. A
// finished result sits in an output register, so the next sample is taken
// while it waits for out_ready.
// Configuration is written over the APB port at byte address 4*index and
// should only change while no transaction is in flight.
module breath_flow_volume_monitor
  import bfvm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  // sample channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [FLOW_W-1:0] flow_sample,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [VOL_W-1:0]         current_volume,
  output logic [VOL_W-1:0]         tidal_volume_out,
  output logic [RATE_W-1:0]        rate_out,
  output logic [MV_W-1:0]          minute_volume_out,
  output logic                     rate_alarm,
  output logic                     volume_alarm,
  output logic                     breath_start,
  output logic                     breath_end
);

  localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = '1;

  // configuration registers
  logic signed [FLOW_W-1:0] threshold_low;
  logic signed [FLOW_W-1:0] threshold_high;
  logic [HZ_W-1:0]          sample_rate_hz;
  logic [GAIN_W-1:0]        volume_gain;
  logic [RATE_W-1:0]        rate_min;
  logic [RATE_W-1:0]        rate_max;
  logic [MV_W-1:0]          minute_volume_min;
  logic [MV_W-1:0]          minute_volume_max;

  // breath state
  logic                     in_inspiration;
  logic [BELOW_W-1:0]       below_count;
  logic [ACC_W-1:0]         volume_accum;
  logic [VOL_W-1:0]         tidal_volume;
  logic [ELAPSED_WIDTH-1:0] samples_since_start;
  logic [RATE_W-1:0]        rate_reg;
  logic [MV_W-1:0]          minute_volume_reg;
  logic [1:0]               alarm_flags;

  // sequencer
  state_t                   state;
  state_t                   state_next;
  logic [CNT_W-1:0]         step;
  logic                     started;
  logic                     ended;

  // serial volume multiplier
  logic signed [VPROD_W-1:0] vprod;
  logic signed [VPROD_W-1:0] mcand;
  logic [GAIN_W-1:0]         gain_sh;

  // restoring divider for the rate
  logic [DIVIDEND_W-1:0]     dvd_sh;
  logic [ELAPSED_WIDTH-1:0]  div_sor;
  logic [ELAPSED_WIDTH-1:0]  rem;
  logic [DIVIDEND_W-1:0]     quot;

  // serial minute volume multiplier
  logic [RATE_W-1:0]         mv_mlt;
  logic [MV_PROD_W-1:0]      mv_mcand;
  logic [MV_PROD_W-1:0]      mv_acc;

  // control strobes
  logic accept;
  logic calc_last;
  logic mv_last;
  logic out_free;
  logic out_load;

  //--------------------------------------------------------------------------
  // configuration port
  //--------------------------------------------------------------------------
  reg_idx_t cfg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_low     <= FLOW_W'(THRESHOLD_LOW_RST);
      threshold_high    <= FLOW_W'(THRESHOLD_HIGH_RST);
      sample_rate_hz    <= HZ_W'(SAMPLE_RATE_HZ_RST);
      volume_gain       <= GAIN_W'(VOLUME_GAIN_RST);
      rate_min          <= RATE_W'(RATE_MIN_RST);
      rate_max          <= RATE_W'(RATE_MAX_RST);
      minute_volume_min <= MV_W'(MINUTE_VOLUME_MIN_RST);
      minute_volume_max <= MV_W'(MINUTE_VOLUME_MAX_RST);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_THRESHOLD_LOW:     threshold_low     <= pwdata[FLOW_W-1:0];
        REG_THRESHOLD_HIGH:    threshold_high    <= pwdata[FLOW_W-1:0];
        REG_SAMPLE_RATE_HZ:    sample_rate_hz    <= pwdata[HZ_W-1:0];
        REG_VOLUME_GAIN:       volume_gain       <= pwdata[GAIN_W-1:0];
        REG_RATE_MIN:          rate_min          <= pwdata[RATE_W-1:0];
        REG_RATE_MAX:          rate_max          <= pwdata[RATE_W-1:0];
        REG_MINUTE_VOLUME_MIN: minute_volume_min <= pwdata[MV_W-1:0];
        REG_MINUTE_VOLUME_MAX: minute_volume_max <= pwdata[MV_W-1:0];
        default: ;
      endcase
    end
  end

  // read back; thresholds return their raw two's complement bits
  always_comb begin
    case (cfg_idx)
      REG_THRESHOLD_LOW:     prdata = DATA_W'($unsigned(threshold_low));
      REG_THRESHOLD_HIGH:    prdata = DATA_W'($unsigned(threshold_high));
      REG_SAMPLE_RATE_HZ:    prdata = DATA_W'(sample_rate_hz);
      REG_VOLUME_GAIN:       prdata = DATA_W'(volume_gain);
      REG_RATE_MIN:          prdata = DATA_W'(rate_min);
      REG_RATE_MAX:          prdata = DATA_W'(rate_max);
      REG_MINUTE_VOLUME_MIN: prdata = DATA_W'(minute_volume_min);
      REG_MINUTE_VOLUME_MAX: prdata = DATA_W'(minute_volume_max);
      default:               prdata = '0;
    endcase
  end

  //--------------------------------------------------------------------------
  // breath detection, evaluated in the accept cycle
  //--------------------------------------------------------------------------
  logic [ELAPSED_WIDTH-1:0] sss_inc;
  logic                     flow_lo;
  logic                     flow_hi;
  logic [BELOW_W-1:0]       bc_inc;
  logic                     end_hit;
  logic                     insp_after_end;
  logic                     start_hit;
  logic [DIVIDEND_W-1:0]    dvd_init;

  always_comb begin
    // elapsed count includes this sample and saturates
    sss_inc = (samples_since_start == ELAPSED_MAX) ? samples_since_start
                                                   : samples_since_start + 1'b1;
    flow_lo = flow_sample < threshold_low;
    flow_hi = flow_sample > threshold_high;
    // low samples are counted only during inspiration; the count clears when the breath ends
    bc_inc  = (in_inspiration && flow_lo) ? below_count + 1'b1 : below_count;
    end_hit = in_inspiration && (bc_inc > BELOW_W'(END_COUNT_LIMIT));
    insp_after_end = in_inspiration && !end_hit;
    // a high sample starts a breath only outside inspiration or on the sample that ends it
    start_hit = flow_hi && !insp_after_end;
    dvd_init  = DIVIDEND_W'(sample_rate_hz) * DIVIDEND_W'(RATE_SCALE);
  end

  //--------------------------------------------------------------------------
  // divider step and result shaping
  //--------------------------------------------------------------------------
  logic [ELAPSED_WIDTH:0]   trial;
  logic [ELAPSED_WIDTH+1:0] diff;
  logic                     div_ge;
  logic [DIVIDEND_W-1:0]    quot_next;
  logic [RATE_W-1:0]        rate_sat;

  always_comb begin
    trial     = {rem, dvd_sh[DIVIDEND_W-1]};
    diff      = {1'b0, trial} - {2'b00, div_sor};
    div_ge    = !diff[ELAPSED_WIDTH+1];
    quot_next = {quot[DIVIDEND_W-2:0], div_ge};
    // the last quotient bit enters here, so the rate is taken from quot_next
    rate_sat  = (|quot_next[DIVIDEND_W-1:RATE_W]) ? '1 : quot_next[RATE_W-1:0];
  end

  logic signed [ACC_W+1:0] vol_sum;
  logic [ACC_W-1:0]        acc_next;
  logic [MV_W-1:0]         mv_sat;
  logic                    rate_alarm_new;
  logic                    vol_alarm_new;

  always_comb begin
    vol_sum = $signed({2'b00, volume_accum})
            + $signed({{(ACC_W+2-VPROD_W){vprod[VPROD_W-1]}}, vprod});
    // clamp at zero, saturate at the top of the accumulator
    if (vol_sum[ACC_W+1]) begin
      acc_next = '0;
    end else if (vol_sum[ACC_W]) begin
      acc_next = '1;
    end else begin
      acc_next = vol_sum[ACC_W-1:0];
    end
    mv_sat = (|mv_acc[MV_PROD_W-1:MV_W+MV_SHIFT]) ? '1
                                                  : mv_acc[MV_W+MV_SHIFT-1:MV_SHIFT];
    // strict windows
    rate_alarm_new = !((rate_reg > rate_min) && (rate_reg < rate_max));
    vol_alarm_new  = !((mv_sat > minute_volume_min) && (mv_sat < minute_volume_max));
  end

  //--------------------------------------------------------------------------
  // sequencer
  //--------------------------------------------------------------------------
  assign out_free  = !out_valid || out_ready;
  assign calc_last = started ? (step == CNT_W'(DIVIDEND_W - 1))
                             : (step == CNT_W'(GAIN_W - 1));
  assign mv_last   = step == CNT_W'(RATE_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_CALC;
      ST_CALC: if (calc_last) state_next = started ? ST_MV : ST_DONE;
      ST_MV:   if (mv_last) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  // step counter, cleared on accept and at the end of the calculation phase
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (accept || (state == ST_CALC && calc_last)) begin
      step <= '0;
    end else if (state == ST_CALC || state == ST_MV) begin
      step <= step + 1'b1;
    end
  end

  //--------------------------------------------------------------------------
  // breath state and datapath
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      in_inspiration      <= 1'b0;
      below_count         <= '0;
      volume_accum        <= '0;
      tidal_volume        <= '0;
      samples_since_start <= '0;
      rate_reg            <= '0;
      minute_volume_reg   <= '0;
      alarm_flags         <= '0;
      started             <= 1'b0;
      ended               <= 1'b0;
    end else begin
      if (accept) begin
        samples_since_start <= start_hit ? '0 : sss_inc;
        below_count         <= end_hit ? '0 : bc_inc;
        in_inspiration      <= insp_after_end || flow_hi;
        started             <= start_hit;
        ended               <= end_hit;
        // tidal latch: the accumulator restarts before this sample is added
        if (end_hit) begin
          tidal_volume <= volume_accum[ACC_W-1:ACC_W-VOL_W];
          volume_accum <= '0;
        end
      end
      if (state == ST_CALC && calc_last && started) begin
        rate_reg <= rate_sat;
      end
      if (out_load) begin
        volume_accum <= acc_next;
        if (started) begin
          minute_volume_reg <= mv_sat;
          alarm_flags       <= {vol_alarm_new, rate_alarm_new};
        end
      end
    end
  end

  // shift registers of the serial units; payload only, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      mcand   <= {{(VPROD_W-FLOW_W){flow_sample[FLOW_W-1]}}, flow_sample};
      gain_sh <= volume_gain;
      vprod   <= '0;
      dvd_sh  <= dvd_init;
      div_sor <= sss_inc;
      rem     <= '0;
      quot    <= '0;
    end else if (state == ST_CALC) begin
      // one gain bit per cycle
      if (step < CNT_W'(GAIN_W)) begin
        if (gain_sh[0]) begin
          vprod <= vprod + mcand;
        end
        mcand   <= mcand <<< 1;
        gain_sh <= gain_sh >> 1;
      end
      // one quotient bit per cycle
      if (started) begin
        rem    <= div_ge ? diff[ELAPSED_WIDTH-1:0] : trial[ELAPSED_WIDTH-1:0];
        quot   <= quot_next;
        dvd_sh <= dvd_sh << 1;
      end
      if (calc_last) begin
        mv_mlt   <= rate_sat;
        mv_mcand <= MV_PROD_W'(tidal_volume);
        mv_acc   <= '0;
      end
    end else if (state == ST_MV) begin
      // rate times tidal volume, one rate bit per cycle
      if (mv_mlt[0]) begin
        mv_acc <= mv_acc + mv_mcand;
      end
      mv_mcand <= mv_mcand << 1;
      mv_mlt   <= mv_mlt >> 1;
    end
  end

  //--------------------------------------------------------------------------
  // output register
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      current_volume    <= acc_next[ACC_W-1:ACC_W-VOL_W];
      tidal_volume_out  <= tidal_volume;
      rate_out          <= rate_reg;
      minute_volume_out <= started ? mv_sat : minute_volume_reg;
      rate_alarm        <= started ? rate_alarm_new : alarm_flags[0];
      volume_alarm      <= started ? vol_alarm_new : alarm_flags[1];
      breath_start      <= started;
      breath_end        <= ended;
    end
  end

endmodule

>>> src/bfvm_checker.sv
// port-level checker for the breath flow volume monitor, with its bind
// depends on bfvm_pkg and assert_macros.svh
`include "assert_macros.svh"

module bfvm_checker
  import bfvm_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [VOL_W-1:0]  current_volume,
  input logic [VOL_W-1:0]  tidal_volume_out,
  input logic [RATE_W-1:0] rate_out,
  input logic [MV_W-1:0]   minute_volume_out,
  input logic              rate_alarm,
  input logic              volume_alarm,
  input logic              breath_start,
  input logic              breath_end
);

  logic              in_acc;
  logic              out_acc;
  logic [1:0]        pending;
  logic [RATE_W-1:0] prev_rate;
  logic [MV_W-1:0]   prev_mv;
  logic [VOL_W-1:0]  prev_tidal;
  logic              prev_ra;
  logic              prev_va;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 1'b1;
    end
  end

  // last delivered breath figures; reset matches the block's own state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_rate  <= '0;
      prev_mv    <= '0;
      prev_tidal <= '0;
      prev_ra    <= 1'b0;
      prev_va    <= 1'b0;
    end else if (out_acc) begin
      prev_rate  <= rate_out;
      prev_mv    <= minute_volume_out;
      prev_tidal <= tidal_volume_out;
      prev_ra    <= rate_alarm;
      prev_va    <= volume_alarm;
    end
  end

  `ASSERT_RESET(a_reset_clears_out, clk, rst, !out_valid)

  `ASSERT_IMPLIES(a_no_spurious_result, clk, rst, out_valid, pending != 2'd0)

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(current_volume) && $stable(rate_out))

  `ASSERT_IMPLIES(a_rate_held, clk, rst, out_acc && !breath_start, rate_out == prev_rate && minute_volume_out == prev_mv && rate_alarm == prev_ra && volume_alarm == prev_va)

  `ASSERT_IMPLIES(a_tidal_held, clk, rst, out_acc && !breath_end, tidal_volume_out == prev_tidal)

endmodule

bind breath_flow_volume_monitor bfvm_checker u_bfvm_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .current_volume    (current_volume),
  .tidal_volume_out  (tidal_volume_out),
  .rate_out          (rate_out),
  .minute_volume_out (minute_volume_out),
  .rate_alarm        (rate_alarm),
  .volume_alarm      (volume_alarm),
  .breath_start      (breath_start),
  .breath_end        (breath_end)
);
